// ===== rtl/core/mst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Types, constants and helper functions shared by the sigmoid MLP train core.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int NUM_HIDDEN = 4;
    localparam int SIG_DEPTH  = 256;
    localparam int SIG_BITS   = $clog2(SIG_DEPTH);
    localparam int LANE_W     = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

    localparam int IDX_W      = 7;
    localparam int MUL_W      = 19;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ASR_IN_W   = PROD_W + 8;
    localparam int WIDE_W     = 24;
    localparam int SUM_W      = PROD_W + LANE_W + 1;
    localparam int GRAD_W     = 20;

    localparam int          ONE_Q12  = 4096;
    localparam logic [12:0] LR_RESET = 13'd1229;

    localparam longint Q31_ONE = 64'sd2147483648;

    typedef logic signed [15:0]          t_q12;
    typedef logic [12:0]                 t_prob;
    typedef logic signed [MUL_W-1:0]     t_mul_op;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [WIDE_W-1:0]    t_wide;
    typedef logic signed [GRAD_W-1:0]    t_grad;
    typedef logic [SIG_DEPTH-1:0][12:0]  t_sig_table;

    typedef enum logic [1:0] {
        ACT_INFER,
        ACT_TRAIN,
        ACT_WRITE,
        ACT_READ
    } t_action;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PARAM,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
        ST_M0, ST_M1, ST_M2,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
        ST_T6, ST_T7, ST_T8, ST_T9, ST_T10,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SLOT_W0,
        SLOT_W1,
        SLOT_BIAS,
        SLOT_V
    } t_slot;

    typedef struct packed {
        t_state st;
        logic   wr_en;
        t_slot  slot;
        t_q12   wr_data;
    } t_lane_ctl;

    typedef struct packed {
        t_q12               a;
        t_q12               b;
        logic signed [15:0] err;
        logic [12:0]        lr;
        t_grad              g;
    } t_lane_data;

    typedef struct packed {
        t_q12  w0;
        t_q12  w1;
        t_q12  bias;
        t_q12  v;
        t_prod prod;
        logic  sat;
    } t_lane_stat;

    // e^(-m/4096) in Q1.31, evaluated at elaboration only
    function automatic longint exp_neg(input longint m);
        longint z;
        longint t2;
        longint t3;
        longint t4;
        longint e;
        z  = m <<< 11;
        t2 = (z * z) >>> 31;
        t3 = (t2 * z) >>> 31;
        t4 = (t3 * z) >>> 31;
        e  = Q31_ONE - z + t2 / 2 - t3 / 6 + t4 / 24;
        for (int i = 0; i < 8; i++) begin
            e = (e * e) >>> 31;
        end
        return e;
    endfunction

    // shift-and-subtract quotient of non-negative values, quotient below 2^14
    function automatic longint udiv_q14(input longint n, input longint d);
        longint r;
        longint q;
        r = n;
        q = 0;
        for (int k = 13; k >= 0; k--) begin
            if (r >= (d <<< k)) begin
                r = r - (d <<< k);
                q = q | (longint'(1) <<< k);
            end
        end
        return q;
    endfunction

    function automatic t_sig_table build_sig_table();
        t_sig_table tbl;
        longint     xc;
        longint     m;
        longint     e;
        longint     den;
        longint     num;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            xc  = -32768 + ((2 * longint'(i) + 1) * 65536) / (2 * SIG_DEPTH);
            m   = (xc < 0) ? -xc : xc;
            e   = exp_neg(m);
            den = Q31_ONE + e;
            num = (xc >= 0) ? Q31_ONE : e;
            tbl[i] = 13'(udiv_q14(num * 4096 + den / 2, den));
        end
        return tbl;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

    function automatic t_prob sig_lookup(input t_q12 x);
        logic [15:0] off;
        off = {~x[15], x[14:0]};
        return SIG_TABLE[off[15 -: SIG_BITS]];
    endfunction

    function automatic t_wide asr12(input logic signed [ASR_IN_W-1:0] p);
        logic signed [ASR_IN_W-1:0] s;
        s = p >>> 12;
        return s[WIDE_W-1:0];
    endfunction

    function automatic logic over16(input t_wide v);
        return !((&v[WIDE_W-1:15]) || (~|v[WIDE_W-1:15]));
    endfunction

    function automatic t_q12 clamp16(input t_wide v);
        if (over16(v)) begin
            return v[WIDE_W-1] ? 16'sh8000 : 16'sh7FFF;
        end
        return v[15:0];
    endfunction

endpackage

// ===== rtl/core/mst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_if
// Valid/ready channels of the sigmoid MLP train core.
// ----------------------------------------------------------------------------
interface mst_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] input_a;
    logic signed [15:0] input_b;
    logic [12:0]        target;
    logic [6:0]         param_index;
    logic signed [15:0] param_value;

    modport source (output valid, action, input_a, input_b, target, param_index,
                    param_value, input ready);
    modport sink   (input valid, action, input_a, input_b, target, param_index,
                    param_value, output ready);
endinterface

interface mst_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result_value;
    logic               saturated;

    modport source (output valid, result_value, saturated, input ready);
    modport sink   (input valid, result_value, saturated, output ready);
endinterface

interface mst_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] learning_rate;

    modport source (output valid, learning_rate, input ready);
    modport sink   (input valid, learning_rate, output ready);
endinterface

// ===== rtl/core/mst_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_lane
// One hidden unit: its weights, bias and output weight, one multiplier
// stepped by the shared sequencer for the forward pass and the update.
// ----------------------------------------------------------------------------
module mst_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mst_pkg::t_lane_ctl  i_ctl,
    input  mst_pkg::t_lane_data i_data,
    output mst_pkg::t_lane_stat o_stat
);

    mst_pkg::t_q12    r_w0;
    mst_pkg::t_q12    r_w1;
    mst_pkg::t_q12    r_bias;
    mst_pkg::t_q12    r_v;
    mst_pkg::t_prod   r_prod;
    logic signed [mst_pkg::PROD_W:0] r_acc;
    mst_pkg::t_q12    r_s;
    mst_pkg::t_prob   r_hid;
    mst_pkg::t_grad   r_eh;
    logic signed [11:0] r_dh;
    mst_pkg::t_grad   r_gh1;
    mst_pkg::t_grad   r_gh;
    logic             r_sat;

    mst_pkg::t_mul_op mul_a;
    mst_pkg::t_mul_op mul_b;
    logic signed [mst_pkg::PROD_W:0] f_sum;
    mst_pkg::t_wide   s_pre;
    mst_pkg::t_wide   upd_bias;
    mst_pkg::t_wide   upd_prod;
    logic [13:0]      hid_c;

    assign hid_c = 14'(mst_pkg::ONE_Q12) - 14'(r_hid);

    always_comb begin
        case (i_ctl.st)
            mst_pkg::ST_F0: begin mul_a = mst_pkg::MUL_W'(r_w0); mul_b = mst_pkg::MUL_W'(i_data.a); end
            mst_pkg::ST_F1: begin mul_a = mst_pkg::MUL_W'(r_w1); mul_b = mst_pkg::MUL_W'(i_data.b); end
            mst_pkg::ST_F4: begin mul_a = mst_pkg::MUL_W'(r_v);  mul_b = mst_pkg::MUL_W'(r_hid); end
            mst_pkg::ST_T0: begin mul_a = mst_pkg::MUL_W'(r_v);  mul_b = mst_pkg::MUL_W'(i_data.err); end
            mst_pkg::ST_T1: begin mul_a = mst_pkg::MUL_W'(r_hid); mul_b = mst_pkg::MUL_W'(hid_c); end
            mst_pkg::ST_T3: begin mul_a = mst_pkg::MUL_W'(r_dh); mul_b = mst_pkg::MUL_W'(r_eh); end
            mst_pkg::ST_T5: begin mul_a = mst_pkg::MUL_W'(r_gh1); mul_b = mst_pkg::MUL_W'(i_data.lr); end
            mst_pkg::ST_T7: begin mul_a = mst_pkg::MUL_W'(i_data.g); mul_b = mst_pkg::MUL_W'(r_hid); end
            mst_pkg::ST_T8: begin mul_a = mst_pkg::MUL_W'(r_gh); mul_b = mst_pkg::MUL_W'(i_data.a); end
            mst_pkg::ST_T9: begin mul_a = mst_pkg::MUL_W'(r_gh); mul_b = mst_pkg::MUL_W'(i_data.b); end
            default:        begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign f_sum    = r_acc + (mst_pkg::PROD_W + 1)'(r_prod);
    assign s_pre    = mst_pkg::asr12(mst_pkg::ASR_IN_W'(f_sum)) + mst_pkg::WIDE_W'(r_bias);
    assign upd_bias = mst_pkg::WIDE_W'(r_bias) + mst_pkg::WIDE_W'(r_gh);
    assign upd_prod = mst_pkg::asr12(mst_pkg::ASR_IN_W'(r_prod));

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_ctl.st)
            mst_pkg::ST_F1: r_acc <= (mst_pkg::PROD_W + 1)'(r_prod);
            mst_pkg::ST_F2: r_s   <= mst_pkg::clamp16(s_pre);
            mst_pkg::ST_F3: r_hid <= mst_pkg::sig_lookup(r_s);
            mst_pkg::ST_T1: r_eh  <= mst_pkg::GRAD_W'(upd_prod);
            mst_pkg::ST_T2: r_dh  <= 12'(upd_prod);
            mst_pkg::ST_T4: r_gh1 <= mst_pkg::GRAD_W'(upd_prod);
            mst_pkg::ST_T6: r_gh  <= mst_pkg::GRAD_W'(upd_prod);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0   <= '0;
            r_w1   <= '0;
            r_bias <= '0;
            r_v    <= '0;
            r_sat  <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                case (i_ctl.slot)
                    mst_pkg::SLOT_W0:   r_w0   <= i_ctl.wr_data;
                    mst_pkg::SLOT_W1:   r_w1   <= i_ctl.wr_data;
                    mst_pkg::SLOT_BIAS: r_bias <= i_ctl.wr_data;
                    mst_pkg::SLOT_V:    r_v    <= i_ctl.wr_data;
                    default: ;
                endcase
            end
            case (i_ctl.st)
                mst_pkg::ST_F0: r_sat <= 1'b0;
                mst_pkg::ST_F2: r_sat <= r_sat | mst_pkg::over16(s_pre);
                mst_pkg::ST_T7: begin
                    r_bias <= mst_pkg::clamp16(upd_bias);
                    r_sat  <= r_sat | mst_pkg::over16(upd_bias);
                end
                mst_pkg::ST_T8: begin
                    r_v   <= mst_pkg::clamp16(mst_pkg::WIDE_W'(r_v) + upd_prod);
                    r_sat <= r_sat | mst_pkg::over16(mst_pkg::WIDE_W'(r_v) + upd_prod);
                end
                mst_pkg::ST_T9: begin
                    r_w0  <= mst_pkg::clamp16(mst_pkg::WIDE_W'(r_w0) + upd_prod);
                    r_sat <= r_sat | mst_pkg::over16(mst_pkg::WIDE_W'(r_w0) + upd_prod);
                end
                mst_pkg::ST_T10: begin
                    r_w1  <= mst_pkg::clamp16(mst_pkg::WIDE_W'(r_w1) + upd_prod);
                    r_sat <= r_sat | mst_pkg::over16(mst_pkg::WIDE_W'(r_w1) + upd_prod);
                end
                default: ;
            endcase
        end
    end

    assign o_stat.w0   = r_w0;
    assign o_stat.w1   = r_w1;
    assign o_stat.bias = r_bias;
    assign o_stat.v    = r_v;
    assign o_stat.prod = r_prod;
    assign o_stat.sat  = r_sat;

endmodule

// ===== rtl/core/mlp_sigmoid_train_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_sigmoid_train_step
// Two-input sigmoid MLP with one hidden layer: infer, train, write, read.
// Write and read pass through the parameter state; infer steps the forward
// pass (F0-F4) and the merge (M0-M2); train adds the update (T0-T10).
// One item at a time; a new item is taken once the sequencer is back idle,
// while the previous result may still wait in the output register.
// Synchronous active-low reset zeroes all weights and biases and sets the
// learning rate to 1229 (0.3); no clearing pass is needed.
// ----------------------------------------------------------------------------
module mlp_sigmoid_train_step (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mst_in_if.sink    i_in,
    mst_out_if.source o_out,
    mst_cfg_if.sink   i_cfg
);

    localparam int H = mst_pkg::NUM_HIDDEN;

    mst_pkg::t_state    r_state;
    mst_pkg::t_state    n_state;
    mst_pkg::t_action   r_action;
    mst_pkg::t_q12      r_a;
    mst_pkg::t_q12      r_b;
    logic [12:0]        r_target;
    logic [mst_pkg::IDX_W-1:0] r_idx;
    mst_pkg::t_q12      r_pval;
    logic [12:0]        r_lr;
    mst_pkg::t_prod     r_prod;
    logic signed [mst_pkg::SUM_W-1:0] r_sum;
    mst_pkg::t_q12      r_opre;
    mst_pkg::t_prob     r_o;
    logic signed [11:0] r_d;
    mst_pkg::t_grad     r_g1;
    mst_pkg::t_grad     r_g;
    mst_pkg::t_q12      r_ob;
    logic               r_sat;
    mst_pkg::t_q12      r_result;
    logic               r_out_valid;
    mst_pkg::t_q12      r_out_value;
    logic               r_out_sat;

    mst_pkg::t_lane_ctl  lane_ctl  [H];
    mst_pkg::t_lane_stat lane_stat [H];
    mst_pkg::t_lane_data lane_data;

    logic               in_xfer;
    logic               out_load;
    logic signed [15:0] err;
    logic [13:0]        o_c;
    mst_pkg::t_mul_op   mul_a;
    mst_pkg::t_mul_op   mul_b;
    logic signed [mst_pkg::SUM_W-1:0] lane_sum;
    logic               lane_sat;
    mst_pkg::t_wide     o_pre;
    mst_pkg::t_wide     ob_upd;

    logic [mst_pkg::IDX_W-1:0] idx_off;
    logic [mst_pkg::IDX_W-1:0] idx_half;
    logic [mst_pkg::LANE_W-1:0] sel_lane;
    mst_pkg::t_slot     sel_slot;
    logic               sel_hit;
    logic               sel_ob;
    mst_pkg::t_q12      sel_value;

    // ---------------- lanes ----------------
    assign lane_data.a   = r_a;
    assign lane_data.b   = r_b;
    assign lane_data.err = err;
    assign lane_data.lr  = r_lr;
    assign lane_data.g   = r_g;

    for (genvar j = 0; j < H; j++) begin : g_lane
        mst_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[j]),
            .i_data  (lane_data),
            .o_stat  (lane_stat[j])
        );
    end

    // ---------------- parameter index decode ----------------
    always_comb begin
        idx_off  = '0;
        sel_slot = mst_pkg::SLOT_W0;
        sel_hit  = 1'b0;
        sel_ob   = 1'b0;
        idx_half = r_idx >> 1;
        if (r_idx < mst_pkg::IDX_W'(2 * H)) begin
            idx_off  = idx_half;
            sel_slot = r_idx[0] ? mst_pkg::SLOT_W1 : mst_pkg::SLOT_W0;
            sel_hit  = 1'b1;
        end else if (r_idx < mst_pkg::IDX_W'(3 * H)) begin
            idx_off  = r_idx - mst_pkg::IDX_W'(2 * H);
            sel_slot = mst_pkg::SLOT_BIAS;
            sel_hit  = 1'b1;
        end else if (r_idx < mst_pkg::IDX_W'(4 * H)) begin
            idx_off  = r_idx - mst_pkg::IDX_W'(3 * H);
            sel_slot = mst_pkg::SLOT_V;
            sel_hit  = 1'b1;
        end else if (r_idx == mst_pkg::IDX_W'(4 * H)) begin
            sel_ob   = 1'b1;
        end
        sel_lane = idx_off[mst_pkg::LANE_W-1:0];
    end

    always_comb begin
        sel_value = '0;
        if (sel_ob) begin
            sel_value = r_ob;
        end else if (sel_hit) begin
            case (sel_slot)
                mst_pkg::SLOT_W0:   sel_value = lane_stat[sel_lane].w0;
                mst_pkg::SLOT_W1:   sel_value = lane_stat[sel_lane].w1;
                mst_pkg::SLOT_BIAS: sel_value = lane_stat[sel_lane].bias;
                mst_pkg::SLOT_V:    sel_value = lane_stat[sel_lane].v;
                default:            sel_value = '0;
            endcase
        end
    end

    // ---------------- merge of lane contributions ----------------
    always_comb begin
        lane_sum = '0;
        lane_sat = 1'b0;
        for (int j = 0; j < H; j++) begin
            lane_sum = lane_sum + mst_pkg::SUM_W'(lane_stat[j].prod);
            lane_sat = lane_sat | lane_stat[j].sat;
        end
    end

    assign o_pre  = mst_pkg::asr12(mst_pkg::ASR_IN_W'(r_sum)) + mst_pkg::WIDE_W'(r_ob);
    assign ob_upd = mst_pkg::WIDE_W'(r_ob) + mst_pkg::WIDE_W'(r_g);
    assign err    = $signed({3'b000, r_target}) - $signed({3'b000, r_o});
    assign o_c    = 14'(mst_pkg::ONE_Q12) - 14'(r_o);

    always_comb begin
        case (r_state)
            mst_pkg::ST_T0: begin mul_a = mst_pkg::MUL_W'(r_o);  mul_b = mst_pkg::MUL_W'(o_c); end
            mst_pkg::ST_T2: begin mul_a = mst_pkg::MUL_W'(r_d);  mul_b = mst_pkg::MUL_W'(err); end
            mst_pkg::ST_T4: begin mul_a = mst_pkg::MUL_W'(r_g1); mul_b = mst_pkg::MUL_W'(r_lr); end
            default:        begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // ---------------- sequencer: next state ----------------
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_load = (r_state == mst_pkg::ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mst_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (mst_pkg::t_action'(i_in.action) inside {mst_pkg::ACT_WRITE,
                                                               mst_pkg::ACT_READ}) begin
                        n_state = mst_pkg::ST_PARAM;
                    end else begin
                        n_state = mst_pkg::ST_F0;
                    end
                end
            end
            mst_pkg::ST_PARAM: n_state = mst_pkg::ST_DONE;
            mst_pkg::ST_F0:    n_state = mst_pkg::ST_F1;
            mst_pkg::ST_F1:    n_state = mst_pkg::ST_F2;
            mst_pkg::ST_F2:    n_state = mst_pkg::ST_F3;
            mst_pkg::ST_F3:    n_state = mst_pkg::ST_F4;
            mst_pkg::ST_F4:    n_state = mst_pkg::ST_M0;
            mst_pkg::ST_M0:    n_state = mst_pkg::ST_M1;
            mst_pkg::ST_M1:    n_state = mst_pkg::ST_M2;
            mst_pkg::ST_M2: begin
                n_state = (r_action == mst_pkg::ACT_TRAIN) ? mst_pkg::ST_T0 : mst_pkg::ST_DONE;
            end
            mst_pkg::ST_T0:    n_state = mst_pkg::ST_T1;
            mst_pkg::ST_T1:    n_state = mst_pkg::ST_T2;
            mst_pkg::ST_T2:    n_state = mst_pkg::ST_T3;
            mst_pkg::ST_T3:    n_state = mst_pkg::ST_T4;
            mst_pkg::ST_T4:    n_state = mst_pkg::ST_T5;
            mst_pkg::ST_T5:    n_state = mst_pkg::ST_T6;
            mst_pkg::ST_T6:    n_state = mst_pkg::ST_T7;
            mst_pkg::ST_T7:    n_state = mst_pkg::ST_T8;
            mst_pkg::ST_T8:    n_state = mst_pkg::ST_T9;
            mst_pkg::ST_T9:    n_state = mst_pkg::ST_T10;
            mst_pkg::ST_T10:   n_state = mst_pkg::ST_DONE;
            mst_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = mst_pkg::ST_IDLE;
                end
            end
            default:           n_state = mst_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        i_in.ready  = (r_state == mst_pkg::ST_IDLE);
        i_cfg.ready = 1'b1;
        for (int j = 0; j < H; j++) begin
            lane_ctl[j].st      = r_state;
            lane_ctl[j].slot    = sel_slot;
            lane_ctl[j].wr_data = r_pval;
            lane_ctl[j].wr_en   = (r_state == mst_pkg::ST_PARAM) &&
                                  (r_action == mst_pkg::ACT_WRITE) && sel_hit &&
                                  (sel_lane == mst_pkg::LANE_W'(j));
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_xfer) begin
            r_action <= mst_pkg::t_action'(i_in.action);
            r_a      <= i_in.input_a;
            r_b      <= i_in.input_b;
            r_target <= i_in.target;
            r_idx    <= i_in.param_index;
            r_pval   <= i_in.param_value;
        end
        case (r_state)
            mst_pkg::ST_M0: r_sum  <= lane_sum;
            mst_pkg::ST_M1: r_opre <= mst_pkg::clamp16(o_pre);
            mst_pkg::ST_M2: r_o    <= mst_pkg::sig_lookup(r_opre);
            mst_pkg::ST_T1: r_d    <= 12'(mst_pkg::asr12(mst_pkg::ASR_IN_W'(r_prod)));
            mst_pkg::ST_T3: r_g1   <= mst_pkg::GRAD_W'(mst_pkg::asr12(mst_pkg::ASR_IN_W'(r_prod)));
            mst_pkg::ST_T5: r_g    <= mst_pkg::GRAD_W'(mst_pkg::asr12(mst_pkg::ASR_IN_W'(r_prod)));
            default: ;
        endcase
        if (r_state == mst_pkg::ST_PARAM) begin
            // a write hands back the value just stored
            if (r_action == mst_pkg::ACT_WRITE && (sel_hit || sel_ob)) begin
                r_result <= r_pval;
            end else begin
                r_result <= sel_value;
            end
        end else if (r_state == mst_pkg::ST_M2) begin
            r_result <= mst_pkg::t_q12'({3'b000, mst_pkg::sig_lookup(r_opre)});
        end
        if (out_load) begin
            r_out_value <= r_result;
            r_out_sat   <= (r_action == mst_pkg::ACT_INFER || r_action == mst_pkg::ACT_TRAIN) &&
                           (r_sat || lane_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mst_pkg::ST_IDLE;
            r_lr        <= mst_pkg::LR_RESET;
            r_ob        <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_lr <= i_cfg.learning_rate;
            end
            if (in_xfer) begin
                r_sat <= 1'b0;
            end else if (r_state == mst_pkg::ST_M1) begin
                r_sat <= r_sat | mst_pkg::over16(o_pre);
            end else if (r_state == mst_pkg::ST_T10) begin
                r_ob  <= mst_pkg::clamp16(ob_upd);
                r_sat <= r_sat | mst_pkg::over16(ob_upd);
            end
            if (r_state == mst_pkg::ST_PARAM && r_action == mst_pkg::ACT_WRITE && sel_ob) begin
                r_ob <= r_pval;
            end
            // hold the result until the transfer, then take the next one
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.saturated    = r_out_sat;

endmodule

// ===== rtl/core/mst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks of the sigmoid MLP train core, bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_value,
    input logic        i_out_sat
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) &&
        $stable(i_out_sat))
        else $error("result changed while stalled");

    // reset leaves no result and an open input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("bad state after reset");

    // one item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

endmodule

bind mlp_sigmoid_train_step mst_checker u_mst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.result_value),
    .i_out_sat   (o_out.saturated)
);
